// ----- hw/rtl/rhwf_pkg.sv -----
// ----------------------------------------------------------------------------
// rhwf_pkg
// Types, codes and constants shared by the right-hand wall follower.
// ----------------------------------------------------------------------------
package rhwf_pkg;

  localparam int NUM_SENSORS   = 8;
  localparam int TIME_W_DEF    = 32;
  localparam int NOW_W         = 32;
  localparam int DIST_W        = 12;
  localparam int DEG_RATE_W    = 10;
  localparam int CM_RATE_W     = 14;
  localparam int CFG_DATA_W    = 14;
  localparam int CFG_IDX_W     = 2;
  localparam int TURN_W        = 8;
  localparam int NEED_W        = TURN_W + CM_RATE_W;

  typedef enum logic [3:0] {
    ST_CHECK_WALL  = 4'd0,
    ST_FIND_WALL   = 4'd1,
    ST_WALL_WAIT   = 4'd2,
    ST_WALL_ORIENT = 4'd3,
    ST_AVOID_COLL  = 4'd4,
    ST_CLAUSTRO    = 4'd5,
    ST_FOLLOW      = 4'd6,
    ST_GO_ON       = 4'd7,
    ST_STAY_CLOSE  = 4'd8,
    ST_RUN_CLOSE   = 4'd9
  } rhwf_state_e;

  typedef enum logic [2:0] {
    CMD_KEEP  = 3'd0,
    CMD_MOVE  = 3'd1,
    CMD_RIGHT = 3'd2,
    CMD_LEFT  = 3'd3,
    CMD_STOP  = 3'd4
  } rhwf_cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NEAR_THR = 2'd0,
    CFG_SIDE_THR = 2'd1,
    CFG_MS_DEG   = 2'd2,
    CFG_MS_CM    = 2'd3
  } rhwf_cfg_idx_e;

  // sensor positions in the input order
  localparam int S_R20  = 0;
  localparam int S_R45  = 1;
  localparam int S_R90  = 2;
  localparam int S_R150 = 3;
  localparam int S_L150 = 4;
  localparam int S_L90  = 5;
  localparam int S_L45  = 6;
  localparam int S_L20  = 7;

  // wall search priority, with the turn for each hit (relative to -20 deg)
  localparam logic [2:0] SCAN_ORDER [NUM_SENSORS] =
    '{3'd0, 3'd1, 3'd7, 3'd2, 3'd6, 3'd3, 3'd5, 3'd4};
  localparam logic [TURN_W-1:0] SCAN_TURN [NUM_SENSORS] =
    '{8'd0, 8'd25, 8'd40, 8'd70, 8'd65, 8'd130, 8'd110, 8'd170};
  localparam logic SCAN_LEFT [NUM_SENSORS] =
    '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1};

  localparam logic [TURN_W-1:0] CORNER_D_CM     = 8'd10;
  localparam logic [TURN_W-1:0] CORNER_X_CM     = 8'd5;
  localparam logic [TURN_W-1:0] WALL_D_CM       = 8'd1;
  localparam logic [TURN_W-1:0] SMALL_TURN_DEG  = 8'd5;
  localparam logic [TURN_W-1:0] CORNER_TURN_DEG = 8'd70;

  localparam logic [DIST_W-1:0]     NEAR_THR_RST = 12'd48;
  localparam logic [DIST_W-1:0]     SIDE_THR_RST = 12'd24;
  localparam logic [DEG_RATE_W-1:0] MS_DEG_RST   = 10'd10;
  localparam logic [CM_RATE_W-1:0]  MS_CM_RST    = 14'd200;

  typedef struct packed {
    logic [DIST_W-1:0]     near_thr;
    logic [DIST_W-1:0]     side_thr;
    logic [DEG_RATE_W-1:0] ms_deg;
    logic [CM_RATE_W-1:0]  ms_cm;
  } rhwf_cfg_t;

  typedef struct packed {
    logic [NUM_SENSORS-1:0] near;
    logic                   side_close;
  } rhwf_sense_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic [3:0] state;
    logic       changed;
  } rhwf_result_t;

endpackage

// ----- hw/rtl/rhwf_cfg.sv -----
// ----------------------------------------------------------------------------
// rhwf_cfg
// Configuration registers with write decode.
// ----------------------------------------------------------------------------
module rhwf_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [rhwf_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [rhwf_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  output rhwf_pkg::rhwf_cfg_t              cfg_o
);
  import rhwf_pkg::*;

  rhwf_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (rhwf_cfg_idx_e'(cfg_idx_i))
        CFG_NEAR_THR: cfg_d.near_thr = cfg_wdata_i[DIST_W-1:0];
        CFG_SIDE_THR: cfg_d.side_thr = cfg_wdata_i[DIST_W-1:0];
        CFG_MS_DEG:   cfg_d.ms_deg   = cfg_wdata_i[DEG_RATE_W-1:0];
        CFG_MS_CM:    cfg_d.ms_cm    = cfg_wdata_i[CM_RATE_W-1:0];
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.near_thr <= NEAR_THR_RST;
      cfg_q.side_thr <= SIDE_THR_RST;
      cfg_q.ms_deg   <= MS_DEG_RST;
      cfg_q.ms_cm    <= MS_CM_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- hw/rtl/rhwf_in_stage.sv -----
// ----------------------------------------------------------------------------
// rhwf_in_stage
// Input register: obstacle flags from the distance compares and the time.
// ----------------------------------------------------------------------------
module rhwf_in_stage #(
  parameter int TIME_WIDTH = rhwf_pkg::TIME_W_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         load_i,
  input  logic                         adv_i,
  input  rhwf_pkg::rhwf_cfg_t          cfg_i,
  input  logic [rhwf_pkg::DIST_W-1:0]  dist_i [rhwf_pkg::NUM_SENSORS],
  input  logic [rhwf_pkg::NOW_W-1:0]   now_ms_i,
  output logic                         valid_o,
  output rhwf_pkg::rhwf_sense_t        sense_o,
  output logic [TIME_WIDTH-1:0]        now_o
);
  import rhwf_pkg::*;

  logic                  valid_q;
  rhwf_sense_t           sense_q, sense_d;
  logic [TIME_WIDTH-1:0] now_q;

  always_comb begin
    for (int i = 0; i < NUM_SENSORS; i++) begin
      sense_d.near[i] = dist_i[i] <= cfg_i.near_thr;
    end
    sense_d.side_close = dist_i[S_R90] <= cfg_i.side_thr;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (adv_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      sense_q <= sense_d;
      now_q   <= TIME_WIDTH'(now_ms_i);
    end
  end

  assign valid_o = valid_q;
  assign sense_o = sense_q;
  assign now_o   = now_q;

endmodule

// ----- hw/rtl/rhwf_core.sv -----
// ----------------------------------------------------------------------------
// rhwf_core
// Follower state machine, entry time, turn angle and wait timer compare.
// ----------------------------------------------------------------------------
module rhwf_core #(
  parameter int TIME_WIDTH = rhwf_pkg::TIME_W_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   adv_i,
  input  rhwf_pkg::rhwf_cfg_t    cfg_i,
  input  rhwf_pkg::rhwf_sense_t  sense_i,
  input  logic [TIME_WIDTH-1:0]  now_i,
  output rhwf_pkg::rhwf_result_t res_o
);
  import rhwf_pkg::*;

  localparam int CMP_W = (TIME_WIDTH > NEED_W) ? TIME_WIDTH : NEED_W;

  rhwf_state_e           state_q, state_d;
  logic [TIME_WIDTH-1:0] entered_q, entered_d;
  logic [TURN_W-1:0]     turn_q, turn_d;

  logic [TURN_W-1:0]     fac_a;
  logic [CM_RATE_W-1:0]  fac_b;
  logic [NEED_W-1:0]     need;
  logic [TIME_WIDTH-1:0] elapsed;
  logic                  waited;
  logic                  found;
  logic [TURN_W-1:0]     scan_turn;
  logic                  scan_left;
  rhwf_cmd_e             cmd;
  logic                  changed;

  // wait length for the current state
  always_comb begin
    fac_a = '0;
    fac_b = '0;
    unique case (state_q) inside
      ST_WALL_WAIT: begin
        fac_a = turn_q;
        fac_b = CM_RATE_W'(cfg_i.ms_deg);
      end
      ST_AVOID_COLL, ST_CLAUSTRO: begin
        fac_a = SMALL_TURN_DEG;
        fac_b = CM_RATE_W'(cfg_i.ms_deg);
      end
      ST_STAY_CLOSE: begin
        fac_a = CORNER_TURN_DEG;
        fac_b = CM_RATE_W'(cfg_i.ms_deg);
      end
      ST_FOLLOW: begin
        fac_a = WALL_D_CM;
        fac_b = cfg_i.ms_cm;
      end
      ST_GO_ON: begin
        fac_a = CORNER_D_CM;
        fac_b = cfg_i.ms_cm;
      end
      ST_RUN_CLOSE: begin
        fac_a = CORNER_X_CM;
        fac_b = cfg_i.ms_cm;
      end
      default: begin
        fac_a = '0;
        fac_b = '0;
      end
    endcase
  end

  assign need    = NEED_W'(fac_a) * NEED_W'(fac_b);
  assign elapsed = now_i - entered_q;
  assign waited  = CMP_W'(elapsed) >= CMP_W'(need);

  // first near sensor in priority order
  always_comb begin
    found     = 1'b0;
    scan_turn = '0;
    scan_left = 1'b0;
    for (int i = 0; i < NUM_SENSORS; i++) begin
      if (!found && sense_i.near[SCAN_ORDER[i]]) begin
        found     = 1'b1;
        scan_turn = SCAN_TURN[i];
        scan_left = SCAN_LEFT[i];
      end
    end
  end

  always_comb begin
    state_d = state_q;
    turn_d  = turn_q;
    cmd     = CMD_KEEP;
    unique case (state_q)
      ST_CHECK_WALL: begin
        if (!found) begin
          state_d = ST_FIND_WALL;
          cmd     = CMD_MOVE;
        end else begin
          state_d = ST_WALL_WAIT;
          turn_d  = scan_turn;
          cmd     = scan_left ? CMD_LEFT : CMD_RIGHT;
        end
      end
      ST_FIND_WALL: begin
        if (sense_i.near[S_R20] || sense_i.near[S_R45] ||
            sense_i.near[S_L20] || sense_i.near[S_L45]) begin
          state_d = ST_CHECK_WALL;
        end
      end
      ST_WALL_WAIT: begin
        if (waited) begin
          state_d = ST_WALL_ORIENT;
          cmd     = CMD_MOVE;
        end
      end
      ST_WALL_ORIENT: begin
        if (sense_i.near[S_R45]) begin
          state_d = ST_AVOID_COLL;
          cmd     = CMD_LEFT;
        end
      end
      ST_AVOID_COLL: begin
        if (sense_i.near[S_R90]) begin
          state_d = ST_CLAUSTRO;
          cmd     = CMD_LEFT;
        end else if (!sense_i.near[S_R45] && waited) begin
          state_d = ST_WALL_ORIENT;
          cmd     = CMD_MOVE;
        end
      end
      ST_CLAUSTRO: begin
        if (!sense_i.near[S_R20] && waited) begin
          state_d = ST_FOLLOW;
          cmd     = CMD_MOVE;
        end
      end
      ST_FOLLOW: begin
        if (sense_i.near[S_R20] || (sense_i.side_close && waited)) begin
          state_d = ST_CLAUSTRO;
          cmd     = CMD_LEFT;
        end else if (!sense_i.near[S_R45]) begin
          state_d = ST_GO_ON;
        end
      end
      ST_GO_ON: begin
        if (sense_i.near[S_R20]) begin
          state_d = ST_CLAUSTRO;
          cmd     = CMD_LEFT;
        end else if (sense_i.near[S_R45]) begin
          state_d = ST_FOLLOW;
          cmd     = CMD_MOVE;
        end else if (waited) begin
          state_d = ST_STAY_CLOSE;
          cmd     = CMD_RIGHT;
        end
      end
      ST_STAY_CLOSE: begin
        if (waited) begin
          state_d = ST_RUN_CLOSE;
          cmd     = CMD_MOVE;
        end
      end
      ST_RUN_CLOSE: begin
        if (sense_i.near[S_R20]) begin
          state_d = ST_WALL_ORIENT;
          cmd     = CMD_MOVE;
        end else if (!sense_i.near[S_R45] && waited) begin
          state_d = ST_STAY_CLOSE;
          cmd     = CMD_RIGHT;
        end
      end
      default: begin
        // illegal encoding: recover with a stop
        state_d = ST_CHECK_WALL;
        cmd     = CMD_STOP;
      end
    endcase
  end

  assign changed   = state_d != state_q;
  assign entered_d = changed ? now_i : entered_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CHECK_WALL;
      entered_q <= '0;
      turn_q    <= '0;
    end else if (adv_i) begin
      state_q   <= state_d;
      entered_q <= entered_d;
      turn_q    <= turn_d;
    end
  end

  assign res_o.cmd     = cmd;
  assign res_o.state   = state_d;
  assign res_o.changed = changed;

endmodule

// ----- hw/rtl/right_hand_wall_follower_unit.sv -----
// ----------------------------------------------------------------------------
// right_hand_wall_follower_unit
// Right-hand wall follower: one motor command per control step request.
// ----------------------------------------------------------------------------
// An accepted request is held in the input register, then its result in the result register.
// Throughput: one request per cycle; the input register hands over to the
// state machine and result register every cycle the output is not stalled.
// Reset: state check_wall, entry time and turn angle zero, configuration at
// its defaults, both stages empty.
module right_hand_wall_follower_unit #(
  parameter int TIME_WIDTH = rhwf_pkg::TIME_W_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [rhwf_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [rhwf_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [rhwf_pkg::DIST_W-1:0]      dist_right_20_i,
  input  logic [rhwf_pkg::DIST_W-1:0]      dist_right_45_i,
  input  logic [rhwf_pkg::DIST_W-1:0]      dist_right_90_i,
  input  logic [rhwf_pkg::DIST_W-1:0]      dist_right_150_i,
  input  logic [rhwf_pkg::DIST_W-1:0]      dist_left_150_i,
  input  logic [rhwf_pkg::DIST_W-1:0]      dist_left_90_i,
  input  logic [rhwf_pkg::DIST_W-1:0]      dist_left_45_i,
  input  logic [rhwf_pkg::DIST_W-1:0]      dist_left_20_i,
  input  logic [rhwf_pkg::NOW_W-1:0]       now_ms_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [2:0]                       motor_cmd_o,
  output logic [3:0]                       nav_state_o,
  output logic                             state_changed_o
);
  import rhwf_pkg::*;

  rhwf_cfg_t             cfg;
  logic [DIST_W-1:0]     dist_vec [NUM_SENSORS];
  logic                  s1_valid;
  rhwf_sense_t           sense;
  logic [TIME_WIDTH-1:0] s1_now;
  logic                  adv;
  logic                  in_load;
  rhwf_result_t          res;
  rhwf_result_t          res_q;
  logic                  out_valid_q;

  assign dist_vec[S_R20]  = dist_right_20_i;
  assign dist_vec[S_R45]  = dist_right_45_i;
  assign dist_vec[S_R90]  = dist_right_90_i;
  assign dist_vec[S_R150] = dist_right_150_i;
  assign dist_vec[S_L150] = dist_left_150_i;
  assign dist_vec[S_L90]  = dist_left_90_i;
  assign dist_vec[S_L45]  = dist_left_45_i;
  assign dist_vec[S_L20]  = dist_left_20_i;

  assign adv        = s1_valid && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid && !adv;
  assign in_load    = in_valid_i && !in_stall_o;

  rhwf_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  rhwf_in_stage #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_in_stage (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (in_load),
    .adv_i    (adv),
    .cfg_i    (cfg),
    .dist_i   (dist_vec),
    .now_ms_i (now_ms_i),
    .valid_o  (s1_valid),
    .sense_o  (sense),
    .now_o    (s1_now)
  );

  rhwf_core #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .cfg_i   (cfg),
    .sense_i (sense),
    .now_i   (s1_now),
    .res_o   (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign motor_cmd_o     = res_q.cmd;
  assign nav_state_o     = res_q.state;
  assign state_changed_o = res_q.changed;

  // a command is only issued on a state change
  a_cmd_needs_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !state_changed_o |-> motor_cmd_o == CMD_KEEP)
    else $error("motor command without state change");

  // the input side only stalls behind a full, stalled result register
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output backpressure");

  // entering the turn wait always starts a rotation
  a_wait_turns: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && state_changed_o && nav_state_o == ST_WALL_WAIT |->
      motor_cmd_o == CMD_LEFT || motor_cmd_o == CMD_RIGHT)
    else $error("turn wait entered without rotation");

endmodule
